/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wpe_pkg.sv */
package wpe_pkg;

    localparam int MAX_WORD_BITS = 32;
    localparam int WORD_W        = MAX_WORD_BITS;
    localparam int POS_W         = (MAX_WORD_BITS > 1) ? $clog2(MAX_WORD_BITS) : 1;

    localparam int IN_WORD_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int TIME_W    = 16;
    localparam int BPL_W     = 6;
    localparam int LPF_W     = 13;
    localparam int LED_W     = 12;
    localparam int DUR_W     = 20;

    localparam logic [BPL_W-1:0] BPL_RESET   = BPL_W'(24);
    localparam logic [LPF_W-1:0] LPF_RESET   = LPF_W'(1);
    localparam logic [LPF_W-1:0] FRAME_MAX   = LPF_W'(4096);
    localparam logic [DUR_W-1:0] BREAK_RESET = DUR_W'(100000);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH  = 3'd0,
        CFG_ZERO_LOW   = 3'd1,
        CFG_ONE_HIGH   = 3'd2,
        CFG_ONE_LOW    = 3'd3,
        CFG_BITS       = 3'd4,
        CFG_LEDS       = 3'd5,
        CFG_BREAK      = 3'd6
    } cfg_idx_t;

    localparam logic OP_COLOR = 1'b0;
    localparam logic OP_BREAK = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] zero_high_time;
        logic [TIME_W-1:0] zero_low_time;
        logic [TIME_W-1:0] one_high_time;
        logic [TIME_W-1:0] one_low_time;
        logic [BPL_W-1:0]  bits_per_led;
        logic [LPF_W-1:0]  leds_per_frame;
        logic [DUR_W-1:0]  break_length;
    } cfg_t;

    // One classified transaction waiting for the segment sequencer.
    typedef struct packed {
        logic              is_break;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  top_pos;
        logic              frame_end;
    } entry_t;

endpackage

/* rtl/core/wpe_cfg.sv */
module wpe_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpe_pkg::CFG_DAT_W-1:0]  cfg_data,
    output wpe_pkg::cfg_t                  cfg
);

    wpe_pkg::cfg_t cfg_reg;
    wpe_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                wpe_pkg::CFG_ZERO_HIGH:
                    cfg_next.zero_high_time = cfg_data[wpe_pkg::TIME_W-1:0];
                wpe_pkg::CFG_ZERO_LOW:
                    cfg_next.zero_low_time  = cfg_data[wpe_pkg::TIME_W-1:0];
                wpe_pkg::CFG_ONE_HIGH:
                    cfg_next.one_high_time  = cfg_data[wpe_pkg::TIME_W-1:0];
                wpe_pkg::CFG_ONE_LOW:
                    cfg_next.one_low_time   = cfg_data[wpe_pkg::TIME_W-1:0];
                wpe_pkg::CFG_BITS:
                    cfg_next.bits_per_led   = cfg_data[wpe_pkg::BPL_W-1:0];
                wpe_pkg::CFG_LEDS:
                    cfg_next.leds_per_frame = cfg_data[wpe_pkg::LPF_W-1:0];
                wpe_pkg::CFG_BREAK:
                    cfg_next.break_length   = cfg_data[wpe_pkg::DUR_W-1:0];
                default: ;  // unmapped index, drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_high_time <= '0;
            cfg_reg.zero_low_time  <= '0;
            cfg_reg.one_high_time  <= '0;
            cfg_reg.one_low_time   <= '0;
            cfg_reg.bits_per_led   <= wpe_pkg::BPL_RESET;
            cfg_reg.leds_per_frame <= wpe_pkg::LPF_RESET;
            cfg_reg.break_length   <= wpe_pkg::BREAK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/wpe_front.sv */
module wpe_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wpe_pkg::cfg_t                  cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [wpe_pkg::IN_WORD_W-1:0]  s_color_word,
    input  logic                           q_full,
    output logic                           q_push,
    output wpe_pkg::entry_t                q_entry
);

    logic [wpe_pkg::LED_W-1:0] led_index_reg;
    logic [wpe_pkg::LED_W-1:0] led_index_next;
    logic [wpe_pkg::LPF_W-1:0] frame;
    logic [wpe_pkg::LPF_W-1:0] count;
    logic [wpe_pkg::POS_W-1:0] top_pos;
    logic                      fend;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Clamp frame length to 1..FRAME_MAX.
    always_comb begin
        if (cfg.leds_per_frame == '0) begin
            frame = wpe_pkg::LPF_W'(1);
        end else if (cfg.leds_per_frame > wpe_pkg::FRAME_MAX) begin
            frame = wpe_pkg::FRAME_MAX;
        end else begin
            frame = cfg.leds_per_frame;
        end
    end

    // Index of the first bit sent, from the clamped bit count.
    always_comb begin
        if (cfg.bits_per_led == '0) begin
            top_pos = '0;
        end else if (cfg.bits_per_led > wpe_pkg::BPL_W'(wpe_pkg::MAX_WORD_BITS)) begin
            top_pos = wpe_pkg::POS_W'(wpe_pkg::MAX_WORD_BITS - 1);
        end else begin
            top_pos = wpe_pkg::POS_W'(cfg.bits_per_led - 1'b1);
        end
    end

    assign count = {1'b0, led_index_reg} + wpe_pkg::LPF_W'(1);
    assign fend  = (count >= frame);

    always_comb begin
        q_entry.is_break  = (s_opcode == wpe_pkg::OP_BREAK);
        q_entry.word      = s_color_word[wpe_pkg::WORD_W-1:0];
        q_entry.top_pos   = top_pos;
        q_entry.frame_end = fend;
    end

    always_comb begin
        led_index_next = led_index_reg;
        if (q_push && (s_opcode == wpe_pkg::OP_COLOR)) begin
            led_index_next = fend ? '0 : count[wpe_pkg::LED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_index_reg <= '0;
        end else begin
            led_index_reg <= led_index_next;
        end
    end

endmodule

/* rtl/core/wpe_queue.sv */
module wpe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wpe_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output wpe_pkg::entry_t head_entry
);

    wpe_pkg::entry_t slot_reg [wpe_pkg::QUEUE_DEPTH];

    logic [wpe_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wpe_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wpe_pkg::QCNT_W-1:0] count_reg,  count_next;

    function automatic logic [wpe_pkg::QPTR_W-1:0] bump(
        input logic [wpe_pkg::QPTR_W-1:0] p);
        if (p == wpe_pkg::QPTR_W'(wpe_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full       = (count_reg == wpe_pkg::QCNT_W'(wpe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/wpe_back.sv */
module wpe_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wpe_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  wpe_pkg::entry_t             q_entry,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_pin_level,
    output logic [wpe_pkg::DUR_W-1:0]   m_duration,
    output logic                        m_item_last,
    output logic                        m_frame_end
);

    wpe_pkg::entry_t            cur_reg,       cur_next;
    logic                       cur_valid_reg, cur_valid_next;
    logic                       low_reg,       low_next;
    logic [wpe_pkg::POS_W-1:0]  pos_reg,       pos_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_level_reg;
    logic [wpe_pkg::DUR_W-1:0]  out_dur_reg;
    logic                       out_last_reg;
    logic                       out_fend_reg;

    logic                       advance, step, finishing, load, bit_val;
    logic                       seg_level, seg_last, seg_fend;
    logic [wpe_pkg::DUR_W-1:0]  seg_dur;

    assign advance = !out_valid_reg || m_ready;
    assign step    = advance && cur_valid_reg;
    assign bit_val = cur_reg.word[pos_reg];

    // Build the segment for the current position.
    always_comb begin
        if (cur_reg.is_break) begin
            seg_level = 1'b0;
            seg_dur   = cfg.break_length;
            seg_last  = 1'b1;
            seg_fend  = 1'b0;
        end else if (!low_reg) begin
            seg_level = 1'b1;
            seg_dur   = wpe_pkg::DUR_W'(bit_val ? cfg.one_high_time : cfg.zero_high_time);
            seg_last  = 1'b0;
            seg_fend  = 1'b0;
        end else begin
            seg_level = 1'b0;
            seg_dur   = wpe_pkg::DUR_W'(bit_val ? cfg.one_low_time : cfg.zero_low_time);
            seg_last  = (pos_reg == '0);
            seg_fend  = (pos_reg == '0) && cur_reg.frame_end;
        end
    end

    assign finishing = seg_last;
    assign load      = q_valid && (!cur_valid_reg || (step && finishing));
    assign q_pop     = load;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        low_next       = low_reg;
        pos_next       = pos_reg;
        if (load) begin
            cur_next       = q_entry;
            cur_valid_next = 1'b1;
            low_next       = 1'b0;
            pos_next       = q_entry.top_pos;
        end else if (step) begin
            if (finishing) begin
                cur_valid_next = 1'b0;
            end else if (low_reg) begin
                low_next = 1'b0;
                pos_next = pos_reg - 1'b1;
            end else begin
                low_next = 1'b1;
            end
        end
        out_valid_next = advance ? step : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_level_reg <= seg_level;
            out_dur_reg   <= seg_dur;
            out_last_reg  <= seg_last;
            out_fend_reg  <= seg_fend;
        end
        if (load) begin
            cur_reg <= cur_next;
        end
        pos_reg <= pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            low_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            low_reg       <= low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pin_level = out_level_reg;
    assign m_duration  = out_dur_reg;
    assign m_item_last = out_last_reg;
    assign m_frame_end = out_fend_reg;

endmodule

/* rtl/core/ws2812_pulse_encoder_top.sv */
// WS2812 pulse encoder. Each input transaction is either a colour word
// (opcode 0) or a reset break (opcode 1). A colour word sends its low
// bits_per_led bits (0 treated as 1, above 32 treated as 32), most significant
// bit first; every bit becomes a high segment then a low segment, timed by the
// one_* or zero_* registers, so a colour transaction yields 2*bits_per_led
// output transactions (48 for the usual 24-bit word). A break yields one low
// segment of break_length. item_last marks the final segment of each input
// transaction; frame_end marks the final segment of the LED that completes a
// frame of leds_per_frame LEDs (0 treated as 1, above 4096 as 4096). Output
// rate is one segment per cycle while m_ready is high and input is queued: the
// segment sequencer steps one half-bit per clock, and a stall holds it. The
// front end classifies and counts LEDs at accept time and parks up to two
// transactions in a queue, so the next word is taken while the current one is
// still being sent and there is no gap between words. Write configuration
// only while idle; cfg_ready is always high and writes to index 7 are dropped.
module ws2812_pulse_encoder_top (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpe_pkg::CFG_DAT_W-1:0]  cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [wpe_pkg::IN_WORD_W-1:0]  s_color_word,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_pin_level,
    output logic [wpe_pkg::DUR_W-1:0]      m_duration,
    output logic                           m_item_last,
    output logic                           m_frame_end
);

    wpe_pkg::cfg_t   cfg;
    wpe_pkg::entry_t push_entry;
    wpe_pkg::entry_t head_entry;
    logic            q_push, q_full, q_pop, q_valid;

    // Configuration registers.
    wpe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Accept, clamp the bit count and advance the LED counter.
    wpe_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_color_word (s_color_word),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (push_entry)
    );

    // Decouple front from sequencer.
    wpe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    // Step through segments and hold each in the output register.
    wpe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_entry     (head_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pin_level (m_pin_level),
        .m_duration  (m_duration),
        .m_item_last (m_item_last),
        .m_frame_end (m_frame_end)
    );

endmodule

/* rtl/core/wpe_checker.sv */
`include "assert_macros.svh"

module wpe_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_pin_level,
    input logic m_item_last,
    input logic m_frame_end
);

    // A stalled output transaction stays offered.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "output dropped while stalled")

    // Frame end only on the last segment of a transaction.
    `ASSERT_SAME(a_fend_last, aclk, aresetn, m_valid && m_frame_end, m_item_last, "frame_end without item_last")

    // A high segment never closes a transaction.
    `ASSERT_SAME(a_high_not_last, aclk, aresetn, m_valid && m_pin_level, !m_item_last, "high segment marked last")

    // The low half of a bit follows its high half at once.
    `ASSERT_NEXT(a_low_follows, aclk, aresetn, m_valid && m_ready && m_pin_level, m_valid && !m_pin_level, "high segment not followed by low")

endmodule

bind ws2812_pulse_encoder_top wpe_checker u_wpe_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pin_level (m_pin_level),
    .m_item_last (m_item_last),
    .m_frame_end (m_frame_end)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

// Expected segment stream for the pulse encoder, kept in order of acceptance.
class segment_scoreboard;
    typedef struct packed {
        logic                      level;
        logic [wpe_pkg::DUR_W-1:0] dur;
        logic                      last;
        logic                      fend;
    } segment_t;

    wpe_pkg::cfg_t               regs;
    logic [wpe_pkg::LED_W-1:0]   led_count;
    segment_t                    expected_segs[$];
    int mismatches;
    int checked;
    int colors;
    int breaks;
    int frame_ends;
    int writes;

    function new();
        regs                = '0;
        regs.bits_per_led   = wpe_pkg::BPL_RESET;
        regs.leds_per_frame = wpe_pkg::LPF_RESET;
        regs.break_length   = wpe_pkg::BREAK_RESET;
        led_count           = '0;
        mismatches          = 0;
        checked             = 0;
        colors              = 0;
        breaks              = 0;
        frame_ends          = 0;
        writes              = 0;
    endfunction

    function int pending();
        return expected_segs.size();
    endfunction

    function void write_reg(logic [wpe_pkg::CFG_IDX_W-1:0] idx,
                            logic [wpe_pkg::CFG_DAT_W-1:0] data);
        writes++;
        case (idx)
            wpe_pkg::CFG_ZERO_HIGH: regs.zero_high_time = data[wpe_pkg::TIME_W-1:0];
            wpe_pkg::CFG_ZERO_LOW:  regs.zero_low_time  = data[wpe_pkg::TIME_W-1:0];
            wpe_pkg::CFG_ONE_HIGH:  regs.one_high_time  = data[wpe_pkg::TIME_W-1:0];
            wpe_pkg::CFG_ONE_LOW:   regs.one_low_time   = data[wpe_pkg::TIME_W-1:0];
            wpe_pkg::CFG_BITS:      regs.bits_per_led   = data[wpe_pkg::BPL_W-1:0];
            wpe_pkg::CFG_LEDS:      regs.leds_per_frame = data[wpe_pkg::LPF_W-1:0];
            wpe_pkg::CFG_BREAK:     regs.break_length   = data[wpe_pkg::DUR_W-1:0];
            default: ;
        endcase
    endfunction

    // Expand one accepted transaction: high/low pairs, or one break segment.
    function void note_item(logic op, logic [wpe_pkg::IN_WORD_W-1:0] word);
        int       nbits;
        int       frame_len;
        int       count;
        int       i;
        logic     bit_v;
        logic     led_done;
        logic     last;
        segment_t seg;

        if (op == wpe_pkg::OP_BREAK) begin
            breaks++;
            seg.level = 1'b0;
            seg.dur   = regs.break_length;
            seg.last  = 1'b1;
            seg.fend  = 1'b0;
            expected_segs.push_back(seg);
            return;
        end
        colors++;
        nbits = int'(regs.bits_per_led);
        if (nbits == 0) nbits = 1;
        if (nbits > wpe_pkg::MAX_WORD_BITS) nbits = wpe_pkg::MAX_WORD_BITS;
        frame_len = int'(regs.leds_per_frame);
        if (frame_len == 0) frame_len = 1;
        if (frame_len > int'(wpe_pkg::FRAME_MAX)) frame_len = int'(wpe_pkg::FRAME_MAX);
        count    = int'(led_count) + 1;
        led_done = (count >= frame_len);

        for (i = 0; i < nbits; i++) begin
            bit_v     = word[wpe_pkg::POS_W'(nbits - 1 - i)];
            last      = (i == nbits - 1);
            seg.level = 1'b1;
            seg.dur   = wpe_pkg::DUR_W'(bit_v ? regs.one_high_time : regs.zero_high_time);
            seg.last  = 1'b0;
            seg.fend  = 1'b0;
            expected_segs.push_back(seg);
            seg.level = 1'b0;
            seg.dur   = wpe_pkg::DUR_W'(bit_v ? regs.one_low_time : regs.zero_low_time);
            seg.last  = last;
            seg.fend  = last && led_done;
            expected_segs.push_back(seg);
        end
        if (led_done) frame_ends++;
        led_count = led_done ? '0 : count[wpe_pkg::LED_W-1:0];
    endfunction

    function void check_segment(logic level, logic [wpe_pkg::DUR_W-1:0] dur,
                                logic last, logic fend);
        segment_t want;

        checked++;
        if (expected_segs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected segment: level=%0b dur=%0d last=%0b fend=%0b",
                         $realtime, level, dur, last, fend);
            return;
        end
        want = expected_segs.pop_front();
        if (want.level !== level || want.dur !== dur || want.last !== last ||
            want.fend !== fend) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"[%0t] segment %0d: expected level=%0b dur=%0d last=%0b fend=%0b,",
                          " got level=%0b dur=%0d last=%0b fend=%0b"},
                         $realtime, checked, want.level, want.dur, want.last, want.fend,
                         level, dur, last, fend);
        end
    endfunction
endclass

module tb;

    localparam logic [wpe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = wpe_pkg::CFG_IDX_W'(7);
    localparam int LONG_HOLD  = 300;
    localparam int SETTLE     = 4;
    localparam int END_SETTLE = 20;
    localparam int WATCHDOG   = 3000;

    logic                             aclk         = 1'b0;
    logic                             aresetn      = 1'b0;
    logic                             cfg_valid    = 1'b0;
    logic                             cfg_ready;
    logic [wpe_pkg::CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [wpe_pkg::CFG_DAT_W-1:0]    cfg_data     = '0;
    logic                             s_valid      = 1'b0;
    logic                             s_ready;
    logic                             s_opcode     = wpe_pkg::OP_COLOR;
    logic [wpe_pkg::IN_WORD_W-1:0]    s_color_word = '0;
    logic                             m_valid;
    logic                             m_ready      = 1'b0;
    logic                             m_pin_level;
    logic [wpe_pkg::DUR_W-1:0]        m_duration;
    logic                             m_item_last;
    logic                             m_frame_end;

    segment_scoreboard sb;

    // Idle percentages for each side; changed per phase by the stimulus.
    int send_pct    = 20;
    int recv_pct    = 20;
    // Long receiver hold: the stimulus bumps hold_asked, the receiver answers.
    int hold_asked  = 0;
    int hold_given  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    ws2812_pulse_encoder_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_color_word (s_color_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pin_level  (m_pin_level),
        .m_duration   (m_duration),
        .m_item_last  (m_item_last),
        .m_frame_end  (m_frame_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; pct is the chance of any gap.
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [wpe_pkg::TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return wpe_pkg::TIME_W'($urandom_range(0, 65535));
    endfunction

    // Receiver: random stalls, plus one long hold whenever the stimulus asks.
    always @(posedge aclk) begin : recv_proc
        int gap;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (hold_asked != hold_given) begin
            hold_given <= hold_given + 1;
            m_ready    <= 1'b0;
            stall_left <= LONG_HOLD - 1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            gap = pick_gap(recv_pct);
            if (gap > 0) begin
                m_ready    <= 1'b0;
                stall_left <= gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on every accepted transaction, check every segment, and
    // watch for a stuck design. All sampling happens at the clock edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_item(s_opcode, s_color_word);
            if (m_valid && m_ready)
                sb.check_segment(m_pin_level, m_duration, m_item_last, m_frame_end);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no transaction for %0d cycles, %0d segments outstanding",
                         idle_cycles, sb.pending());
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one transaction and hold it until accepted; valid stays high so a
    // following transaction can go out back to back.
    task automatic send_item(input logic op, input logic [wpe_pkg::IN_WORD_W-1:0] word);
        int gap;
        gap = pick_gap(send_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_color_word <= word;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Write one register; bits above the register width carry random junk.
    task automatic write_reg(input logic [wpe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value, input int width);
        logic [31:0] mask;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ($urandom & ~mask) | (value & mask);
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    // Stop sending and wait for every expected segment, then let things settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [wpe_pkg::TIME_W-1:0] zh,
                              input logic [wpe_pkg::TIME_W-1:0] zl,
                              input logic [wpe_pkg::TIME_W-1:0] oh,
                              input logic [wpe_pkg::TIME_W-1:0] ol,
                              input logic [wpe_pkg::BPL_W-1:0] bits,
                              input logic [wpe_pkg::LPF_W-1:0] leds,
                              input logic [wpe_pkg::DUR_W-1:0] brk);
        drain();
        write_reg(wpe_pkg::CFG_ZERO_HIGH, 32'(zh), wpe_pkg::TIME_W);
        write_reg(wpe_pkg::CFG_ZERO_LOW,  32'(zl), wpe_pkg::TIME_W);
        write_reg(wpe_pkg::CFG_ONE_HIGH,  32'(oh), wpe_pkg::TIME_W);
        write_reg(wpe_pkg::CFG_ONE_LOW,   32'(ol), wpe_pkg::TIME_W);
        write_reg(wpe_pkg::CFG_BITS,      32'(bits), wpe_pkg::BPL_W);
        write_reg(wpe_pkg::CFG_LEDS,      32'(leds), wpe_pkg::LPF_W);
        write_reg(wpe_pkg::CFG_BREAK,     32'(brk), wpe_pkg::DUR_W);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [wpe_pkg::BPL_W-1:0] bits;
        logic [wpe_pkg::LPF_W-1:0] leds;
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0:       bits = wpe_pkg::BPL_W'($urandom_range(0, 63));
            1:       bits = wpe_pkg::BPL_W'(24);
            2:       bits = wpe_pkg::BPL_W'(32);
            default: bits = wpe_pkg::BPL_W'($urandom_range(1, 10));
        endcase
        r = $urandom_range(0, 7);
        case (r)
            0:       leds = '0;
            1:       leds = wpe_pkg::FRAME_MAX;
            2:       leds = wpe_pkg::LPF_W'($urandom_range(0, 8191));
            default: leds = wpe_pkg::LPF_W'($urandom_range(1, 6));
        endcase
        set_config(pick_time(), pick_time(), pick_time(), pick_time(), bits, leds,
                   wpe_pkg::DUR_W'($urandom_range(0, 1048575)));
    endtask

    // Mostly color words with random content, a break now and then.
    task automatic random_items(input int count);
        int i;
        int r;
        logic [wpe_pkg::IN_WORD_W-1:0] word;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 11);
            word = (r == 1) ? '1 : (r == 2) ? '0 : wpe_pkg::IN_WORD_W'($urandom);
            send_item((r == 0) ? wpe_pkg::OP_BREAK : wpe_pkg::OP_COLOR, word);
        end
    endtask

    initial begin : stimulus
        int p;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: 24-bit words, one LED per frame, all bit durations zero.
        send_item(wpe_pkg::OP_COLOR, 32'h00A5_5A0F);
        send_item(wpe_pkg::OP_COLOR, 32'hFF00_00FF);
        send_item(wpe_pkg::OP_BREAK, 32'h1234_5678);

        // Zero bit count and zero frame length act as one; zero-length break.
        set_config('0, '1, '1, '0, '0, '0, '0);
        send_item(wpe_pkg::OP_COLOR, 32'h0000_0001);
        send_item(wpe_pkg::OP_COLOR, 32'h0000_0000);
        send_item(wpe_pkg::OP_COLOR, 32'hFFFF_FFFE);
        send_item(wpe_pkg::OP_BREAK, 32'hFFFF_FFFF);

        // Oversized bit count and frame length clamp; longest break.
        set_config(pick_time(), pick_time(), pick_time(), pick_time(), '1, '1, '1);
        send_item(wpe_pkg::OP_COLOR, 32'hFFFF_FFFF);
        send_item(wpe_pkg::OP_COLOR, 32'h0000_0000);
        send_item(wpe_pkg::OP_COLOR, 32'h8000_0001);
        send_item(wpe_pkg::OP_BREAK, 32'h0);
        send_item(wpe_pkg::OP_COLOR, 32'h5555_AAAA);

        // Shorten the frame while it is under way; also poke the unused index.
        set_config(pick_time(), pick_time(), pick_time(), pick_time(),
                   wpe_pkg::BPL_W'(32), wpe_pkg::LPF_W'(3), wpe_pkg::DUR_W'(100000));
        send_item(wpe_pkg::OP_COLOR, 32'hDEAD_BEEF);
        send_item(wpe_pkg::OP_COLOR, 32'h0F0F_F0F0);
        drain();
        write_reg(wpe_pkg::CFG_LEDS, 32'd2, wpe_pkg::LPF_W);
        write_reg(CFG_UNUSED, $urandom, 32);
        cfg_valid <= 1'b0;
        send_item(wpe_pkg::OP_COLOR, 32'hCAFE_F00D);
        send_item(wpe_pkg::OP_COLOR, 32'h1357_9BDF);

        // Single-bit words in the longest legal frame.
        set_config(pick_time(), pick_time(), pick_time(), pick_time(), wpe_pkg::BPL_W'(1),
                   wpe_pkg::FRAME_MAX, wpe_pkg::DUR_W'($urandom_range(0, 1048575)));
        send_item(wpe_pkg::OP_COLOR, 32'h0000_0000);
        send_item(wpe_pkg::OP_COLOR, 32'h0000_0001);
        send_item(wpe_pkg::OP_BREAK, 32'hA5A5_A5A5);

        for (p = 0; p < 6; p++) begin
            random_config();
            if (p == 1) begin
                // No idling on either side for this phase.
                send_pct = 0;
                recv_pct = 0;
            end else begin
                send_pct = $urandom_range(10, 40);
                recv_pct = $urandom_range(10, 40);
            end
            if (p == 2) begin
                // Hold the receiver off while words keep coming, then pause
                // until the backlog has fully drained.
                hold_asked = hold_asked + 1;
                send_pct   = 0;
                random_items(12);
                drain();
                send_pct = 30;
                random_items(10);
            end else begin
                random_items(22);
            end
        end

        drain();
        repeat (END_SETTLE) @(posedge aclk);

        $display("Sent %0d color words and %0d breaks over %0d register writes;",
                 sb.colors, sb.breaks, sb.writes);
        $display("checked %0d segments, %0d frame ends, %0d mismatches.",
                 sb.checked, sb.frame_ends, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
